// ===== rtl/cbmt_pkg.sv =====
// Shared constants, types and the memory request struct of the counter bank max tracker.
`timescale 1ns / 1ps
`default_nettype none

package cbmt_pkg;

	// Bank geometry.
	localparam int NUM_COUNTERS = 64;
	localparam int COUNT_WIDTH  = 16;

	// Field widths of the item and result ports.
	localparam int IDX_W  = 6;
	localparam int KIND_W = 2;
	localparam int HOLD_W = 7;

	// Address width of the counter memory and width of the scan counter,
	// which must also hold NUM_COUNTERS itself.
	localparam int ADDR_W = $clog2(NUM_COUNTERS);
	localparam int SCAN_W = ADDR_W + 1;

	typedef logic signed [COUNT_WIDTH-1:0] count_t;

	localparam count_t CNT_TOP    = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam count_t CNT_BOTTOM = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// Operation codes of the kind field.
	localparam logic [KIND_W-1:0] KIND_INC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLR   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

	// One read port and one write port of the counter memory.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		count_t            wr_data;
	} store_req_t;

endpackage

`default_nettype wire

// ===== rtl/cbmt_store.sv =====
// Counter memory with registered read and per-entry valid bits for the zero reset.
`timescale 1ns / 1ps
`default_nettype none

module cbmt_store
	import cbmt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output count_t          rd_data
);

	count_t                  mem [NUM_COUNTERS];
	logic [NUM_COUNTERS-1:0] vld_q;
	count_t                  rd_mem_s1;
	logic                    rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_mem_s1 <= mem[req.rd_addr];
		end
	end

	// An entry that was never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_mem_s1 : '0;

endmodule

`default_nettype wire

// ===== rtl/counter_bank_max_tracker_core.sv =====
// Top level of the counter bank max tracker: sequencer, maximum tracking and result register.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   request | req_valid req_stall kind index   | in
//   result  | rsp_valid rsp_stall value        | out
//           | max_value max_holders            |
//
// An item passes through accept, read-modify-write and finish when the
// maximum and its holder count can be updated from the old and new value.
// When the item takes the value away from the only counter at the maximum,
// the memory's single read port scans all 64 counters, one per cycle,
// between the read-modify-write and the finish step.
// After reset every counter reads as zero through cleared valid bits, so
// no clearing pass is needed. A stalled result waits in the output register
// while the next item is already accepted and processed.
`timescale 1ns / 1ps
`default_nettype none

module counter_bank_max_tracker_core
	import cbmt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic [IDX_W-1:0]  index,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output count_t                 value,
	output count_t                 max_value,
	output logic [HOLD_W-1:0]      max_holders
);

	// Sequencer states.
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [KIND_W-1:0] kind_q;
	logic [ADDR_W-1:0] idx_q;
	logic              in_range_q;
	count_t            shown_q;

	// Tracked maximum and how many counters hold it.
	count_t            max_q;
	logic [HOLD_W-1:0] holders_q;

	// Rescan bookkeeping.
	logic [SCAN_W-1:0] scan_q;
	logic              pend_s1;
	count_t            best_q;
	logic [HOLD_W-1:0] cnt_q;

	store_req_t req;
	count_t     rd_data;
	count_t     new_val;
	logic       in_range;
	logic       scan_first;
	count_t     acc_best;
	logic [HOLD_W-1:0] acc_cnt;

	cbmt_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign in_range  = ({1'b0, index} < (IDX_W+1)'(NUM_COUNTERS));

	// Saturating update of the addressed counter.
	always_comb begin
		new_val = rd_data;
		case (kind_q)
			KIND_INC:   new_val = (rd_data != CNT_TOP) ? rd_data + count_t'(1) : rd_data;
			KIND_DEC:   new_val = (rd_data != CNT_BOTTOM) ? rd_data - count_t'(1) : rd_data;
			KIND_CLR:   new_val = '0;
			KIND_QUERY: new_val = rd_data;
		endcase
	end

	// Memory port use: the addressed read on acceptance, the write-back in
	// the modify step, and the sequential reads of a rescan.
	always_comb begin
		req = '0;
		unique case (state_q)
			S_IDLE: begin
				req.rd_en   = req_valid;
				req.rd_addr = index[ADDR_W-1:0];
			end
			S_MOD: begin
				req.wr_en   = in_range_q;
				req.wr_addr = idx_q;
				req.wr_data = new_val;
			end
			S_SCAN: begin
				req.rd_en   = (scan_q != SCAN_W'(NUM_COUNTERS));
				req.rd_addr = scan_q[ADDR_W-1:0];
			end
			S_DONE: begin
				req = '0;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	// Running maximum of the rescan. The data of address k arrives while the
	// scan counter already reads k + 1, so the first word shows at one.
	assign scan_first = (scan_q == SCAN_W'(1));

	always_comb begin
		if (scan_first || (rd_data > best_q)) begin
			acc_best = rd_data;
			acc_cnt  = HOLD_W'(1);
		end else if (rd_data == best_q) begin
			acc_best = best_q;
			acc_cnt  = cnt_q + HOLD_W'(1);
		end else begin
			acc_best = best_q;
			acc_cnt  = cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			kind_q <= kind;
			idx_q  <= index[ADDR_W-1:0];
		end
		if (state_q == S_MOD) begin
			shown_q <= in_range_q ? new_val : '0;
		end
		if (state_q == S_SCAN && pend_s1) begin
			best_q <= acc_best;
			cnt_q  <= acc_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_range_q  <= 1'b0;
			max_q       <= '0;
			holders_q   <= HOLD_W'(NUM_COUNTERS);
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			rsp_valid   <= 1'b0;
			value       <= '0;
			max_value   <= '0;
			max_holders <= '0;
		end else begin
			// Outside the finish step a taken result simply leaves.
			if (rsp_valid && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						in_range_q <= in_range;
						state_q    <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= S_DONE;
					// The maximum follows from the old and new value alone,
					// except when its only holder drops below it.
					if (in_range_q) begin
						if (new_val > max_q) begin
							max_q     <= new_val;
							holders_q <= HOLD_W'(1);
						end else if (new_val == max_q) begin
							if (rd_data != max_q) begin
								holders_q <= holders_q + HOLD_W'(1);
							end
						end else if (rd_data == max_q) begin
							if (holders_q == HOLD_W'(1)) begin
								scan_q  <= '0;
								pend_s1 <= 1'b0;
								state_q <= S_SCAN;
							end else begin
								holders_q <= holders_q - HOLD_W'(1);
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_q != SCAN_W'(NUM_COUNTERS)) begin
						scan_q  <= scan_q + SCAN_W'(1);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (pend_s1 && scan_q == SCAN_W'(NUM_COUNTERS)) begin
						max_q     <= acc_best;
						holders_q <= acc_cnt;
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					// The result register takes the new result once the
					// previous one is gone or leaves in this cycle.
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid   <= 1'b1;
						value       <= shown_q;
						max_value   <= max_q;
						max_holders <= holders_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// An accepted item always goes to its read-modify-write step next.
	a_accept_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_MOD))
		else $error("accepted item did not enter the modify step");

	// At least one counter and at most all of them hold the maximum.
	a_holders_range: assert property (@(posedge clk) disable iff (!arst_n)
		(holders_q != '0) && (holders_q <= HOLD_W'(NUM_COUNTERS)))
		else $error("holder count out of range");

	// A new result appears only from the finish step.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the finish step");

endmodule

`default_nettype wire

// ===== test/counter_bank_max_tracker_check.sv =====
// Result checker for the counter bank max tracker: tracks the bank, predicts and compares.
`timescale 1ns / 1ps

module counter_bank_max_tracker_check
	import cbmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  index,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  count_t            value,
	input  count_t            max_value,
	input  logic [HOLD_W-1:0] max_holders,
	output int                errors,
	output int                in_flight
);

	typedef struct packed {
		count_t            value;
		count_t            max_value;
		logic [HOLD_W-1:0] holders;
	} tally_t;

	count_t bank [NUM_COUNTERS];
	tally_t awaited_q [$];

	// Applies one operation to the bank copy and returns the result it should produce.
	function automatic tally_t apply_op(logic [KIND_W-1:0] op, logic [IDX_W-1:0] idx);
		tally_t t;
		count_t v;
		count_t best;
		int n;
		int k;
		v = bank[idx];
		case (op)
			KIND_INC: if (v != CNT_TOP) v = v + count_t'(1);
			KIND_DEC: if (v != CNT_BOTTOM) v = v - count_t'(1);
			KIND_CLR: v = '0;
			KIND_QUERY: ;
		endcase
		bank[idx] = v;
		best = bank[0];
		n = 0;
		for (k = 0; k < NUM_COUNTERS; k++) begin
			if (bank[k] > best) begin
				best = bank[k];
				n = 1;
			end else if (bank[k] == best) begin
				n++;
			end
		end
		t.value     = v;
		t.max_value = best;
		t.holders   = n[HOLD_W-1:0];
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tally_t want;
		int bad;
		int took;
		int gave;
		int k;
		if (!arst_n) begin
			for (k = 0; k < NUM_COUNTERS; k++)
				bank[k] = '0;
			awaited_q.delete();
			errors    <= 0;
			in_flight <= 0;
		end else begin
			bad  = 0;
			took = 0;
			gave = 0;
			if (rsp_valid && !rsp_stall) begin
				gave = 1;
				if (awaited_q.size() == 0) begin
					$error("result arrived with no item outstanding");
					bad++;
				end else begin
					want = awaited_q.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d",
							$signed(want.value), $signed(value));
						bad++;
					end
					if (max_value !== want.max_value) begin
						$error("max_value: expected %0d, got %0d",
							$signed(want.max_value), $signed(max_value));
						bad++;
					end
					if (max_holders !== want.holders) begin
						$error("max_holders: expected %0d, got %0d",
							want.holders, max_holders);
						bad++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				took = 1;
				awaited_q = {awaited_q, apply_op(kind, index)};
			end
			errors    <= errors + bad;
			in_flight <= in_flight + took - gave;
		end
	end

endmodule

// ===== test/counter_bank_max_tracker_core_test.sv =====
// Top of the counter bank max tracker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module counter_bank_max_tracker_core_test;
	import cbmt_pkg::*;

	// Length of the ramps that lift one counter far above the rest and sink another.
	localparam int RAMP_ITEMS    = 40;
	localparam int RANDOM_ITEMS  = 600;
	// One long receiver hold-off, well beyond the block's internal buffering.
	localparam int HOLD_CYCLES   = 400;
	// Slowest item is a full rescan; wait a little beyond that at the end.
	localparam int SETTLE_CYCLES = 100;
	// Watchdog limit, set several times over what a correct run needs.
	localparam int LIMIT         = 500_000;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  index;
	logic              rsp_valid;
	logic              rsp_stall;
	count_t            value;
	count_t            max_value;
	logic [HOLD_W-1:0] max_holders;
	int                errors;
	int                in_flight;

	// Stimulus bookkeeping shared with the receiver process.
	int sent;
	int rand_base;
	bit calm;
	bit hold_off;

	counter_bank_max_tracker_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.index       (index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value),
		.max_value   (max_value),
		.max_holders (max_holders)
	);

	counter_bank_max_tracker_check checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.index       (index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value),
		.max_value   (max_value),
		.max_holders (max_holders),
		.errors      (errors),
		.in_flight   (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one item and returns at the clock edge where it is accepted. Before the
	// item, the sender may idle for a few cycles, except inside the calm stretch.
	// The calm flag is refreshed here so both sides see the same window.
	task automatic send_item(input logic [KIND_W-1:0] op, input logic [IDX_W-1:0] idx);
		calm = (rand_base > 0) && (sent >= rand_base + 250) && (sent < rand_base + 400);
		while (!calm && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= op;
		index     <= idx;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// Random operation, leaning toward increments so that maxima build up and
	// decrements or clears of a sole holder force the block into a rescan.
	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return KIND_INC;
		else if (r < 72)
			return KIND_DEC;
		else if (r < 84)
			return KIND_CLR;
		return KIND_QUERY;
	endfunction

	initial begin : stimulus
		int k;
		int len;
		int span;
		int mode;
		logic [IDX_W-1:0]  hot [4];
		logic [KIND_W-1:0] op;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		kind      = KIND_QUERY;
		index     = '0;
		sent      = 0;
		rand_base = 0;
		calm      = 1'b0;
		hold_off  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Right after reset all 64 counters tie at zero, so the
		// holder count starts at its top. Then a sole maximum is built and lost
		// again, which forces the slow rescan, and a tie of two is broken by a
		// clear, which must not need one.
		send_item(KIND_QUERY, 6'd0);
		send_item(KIND_QUERY, 6'd63);
		send_item(KIND_INC, 6'd63);
		send_item(KIND_INC, 6'd63);
		send_item(KIND_DEC, 6'd63);
		send_item(KIND_DEC, 6'd63);
		send_item(KIND_DEC, 6'd0);
		send_item(KIND_CLR, 6'd0);
		send_item(KIND_INC, 6'd5);
		send_item(KIND_INC, 6'd5);
		send_item(KIND_INC, 6'd42);
		send_item(KIND_INC, 6'd42);
		send_item(KIND_CLR, 6'd5);
		send_item(KIND_DEC, 6'd42);
		send_item(KIND_QUERY, 6'd42);
		send_item(KIND_CLR, 6'd42);
		send_item(KIND_INC, 6'd21);
		send_item(KIND_DEC, 6'd21);
		send_item(KIND_QUERY, 6'd21);

		// Ramps: one counter climbs far above the rest and another sinks far
		// below, so a single counter holds the maximum for a long run.
		for (k = 0; k < RAMP_ITEMS; k++)
			send_item(KIND_INC, 6'd33);
		for (k = 0; k < RAMP_ITEMS; k++)
			send_item(KIND_DEC, 6'd30);
		send_item(KIND_QUERY, 6'd33);
		send_item(KIND_QUERY, 6'd30);
		// Clearing the sole holder of the top value triggers a rescan.
		send_item(KIND_CLR, 6'd33);
		send_item(KIND_CLR, 6'd30);

		// Random part. Most bursts work a small set of counters so that values
		// drift apart and the maximum keeps moving between them. Sweeps across
		// the whole bank drive every counter the same way, which brings ties of
		// all 64 counters and negative maxima. The rest is scattered noise.
		rand_base = sent;
		hold_off  = 1'b1;
		while (sent < rand_base + RANDOM_ITEMS) begin
			mode = $urandom_range(9);
			if (mode < 6) begin
				span = $urandom_range(4, 2);
				for (k = 0; k < 4; k++)
					hot[k] = IDX_W'($urandom_range(NUM_COUNTERS - 1));
				len = $urandom_range(30, 10);
				for (k = 0; k < len; k++)
					send_item(pick_kind(), hot[2'($urandom_range(span - 1))]);
			end else if (mode < 8) begin
				len = $urandom_range(20, 5);
				for (k = 0; k < len; k++)
					send_item(KIND_W'($urandom_range(3)),
						IDX_W'($urandom_range(NUM_COUNTERS - 1)));
			end else begin
				case ($urandom_range(2))
					0:       op = KIND_INC;
					1:       op = KIND_DEC;
					default: op = KIND_CLR;
				endcase
				for (k = 0; k < NUM_COUNTERS; k++)
					send_item(op, k[IDX_W-1:0]);
			end
		end
		req_valid <= 1'b0;

		// The checker's count is registered and shows an edge only in the next cycle, so step once
		// before looking at it.
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Result side. Stalls at random, except inside the calm stretch. Once, at the
	// start of the random part, it holds off for a long stretch while the sender
	// keeps offering items, so the block backs up and stalls its input.
	initial begin : drain
		int waited;
		bit held;
		rsp_stall = 1'b0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				for (waited = 0; waited < HOLD_CYCLES; waited++)
					@(posedge clk);
			end else begin
				rsp_stall <= arst_n && !calm && ($urandom_range(99) < 19);
			end
		end
	end

	// A hung block would otherwise leave the run waiting forever.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cbmt_pkg.sv
rtl/cbmt_store.sv
rtl/counter_bank_max_tracker_core.sv
test/counter_bank_max_tracker_check.sv
test/counter_bank_max_tracker_core_test.sv
